FILE: design/date_day_number_converter_macros.svh
// assertion macros used by the converter control module
// expects clk and rst_n to be visible where the macros are used
`ifndef DATE_DAY_NUMBER_CONVERTER_MACROS_SVH
`define DATE_DAY_NUMBER_CONVERTER_MACROS_SVH

// same-cycle implication
`define DDNC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define DDNC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: design/ddnc_pkg.sv
// shared constants, tables and types for the date / day number converter
// no dependencies
package ddnc_pkg;

    localparam int NUM_STAGES = 6;

    // date to day number
    localparam logic [21:0] EPOCH_OFFSET = 22'd693961;
    localparam logic [21:0] EPOCH_LAST   = 22'd759496;
    localparam logic [12:0] RECIP_100    = 13'd5243;   // >> 19

    // day number to date
    localparam logic [19:0] MARCH_OFFSET = 20'd693901;
    localparam logic [19:0] ERA5_START   = 20'd730485;
    localparam logic [19:0] ERA4_START   = 20'd584388;
    localparam logic [15:0] RECIP_365    = 16'd45965;  // >> 24
    localparam logic [12:0] RECIP_153    = 13'd6854;   // >> 20
    localparam logic [17:0] CENTURY_1    = 18'd36524;
    localparam logic [17:0] CENTURY_2    = 18'd73048;
    localparam logic [17:0] CENTURY_3    = 18'd109572;
    localparam logic [17:0] DOE_LAST     = 18'd146096;
    localparam logic [11:0] ERA5_YEAR    = 12'd2000;
    localparam logic [11:0] ERA4_YEAR    = 12'd1600;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // days before the first of the month, months 0 and 1 give zero
    function automatic logic [8:0] month_prefix(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            4'd13:   days = 9'd365;
            4'd14:   days = 9'd365;
            4'd15:   days = 9'd365;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // first day of each month counted from 1 march, index 0 is march
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] days;
        case (mp)
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

FILE: design/ddnc_in_if.sv
// request channel of the converter: valid / ready with one conversion request
// no dependencies
interface ddnc_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [11:0] in_year;
    logic [15:0] in_day_number;

    modport source (
        output valid, op, in_day, in_month, in_year, in_day_number,
        input  ready
    );
    modport sink (
        input  valid, op, in_day, in_month, in_year, in_day_number,
        output ready
    );
endinterface

FILE: design/ddnc_out_if.sv
// result channel of the converter: valid / ready with one conversion result
// no dependencies
interface ddnc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [11:0] out_year;
    logic        out_of_range;

    modport source (
        output valid, out_day_number, out_day, out_month, out_year, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, out_day_number, out_day, out_month, out_year, out_of_range,
        output ready
    );
endinterface

FILE: design/ddnc_ctrl.sv
// pipeline control: per-stage valid bits, ready chain and the op tag
// depends on ddnc_pkg and date_day_number_converter_macros.svh
`include "date_day_number_converter_macros.svh"

module ddnc_ctrl
    import ddnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_op,
    output logic       in_ready,
    output logic       out_valid,
    output logic       out_op,
    input  logic       out_ready,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] op_reg;
    logic [NUM_STAGES-1:0] rdy;
    logic                  acc_in;
    logic                  acc_out;

    // a stage can take data when empty or when its content moves on
    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            op_reg[0] <= in_op;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                op_reg[k] <= op_reg[k-1];
            end
        end
    end

    assign ctrl.load = rdy;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_op    = op_reg[NUM_STAGES-1];
    assign acc_in    = in_valid && rdy[0];
    assign acc_out   = valid_reg[NUM_STAGES-1] && out_ready;

    // items in flight change only by transfers at the two ends
    `DDNC_ASSERT_NEXT(a_item_count, 1'b1, $countones(valid_reg) == $past($countones(valid_reg)) + $past(int'(acc_in)) - $past(int'(acc_out)))
    // an accepted request lands in the first stage
    `DDNC_ASSERT_NEXT(a_enter_first, acc_in, valid_reg[0])
    // back-pressure only when every stage holds an item
    `DDNC_ASSERT_IMP(a_full_when_blocked, !in_ready, &valid_reg)

endmodule

FILE: design/ddnc_to_number.sv
// date to day number datapath, six register stages
// depends on ddnc_pkg
module ddnc_to_number
    import ddnc_pkg::*;
(
    input  logic        clk,
    input  pipe_ctrl_t  ctrl,
    input  logic [4:0]  in_day,
    input  logic [3:0]  in_month,
    input  logic [11:0] in_year,
    output logic [15:0] day_number,
    output logic        in_range
);

    // stage 1
    logic [20:0] prod_reg, prod_next;
    logic [8:0]  part_reg, part_next;
    logic [11:0] ly_reg, ly_next;
    logic        lzero1_reg, lzero1_next;
    // stage 2
    logic [24:0] q100_prod;
    logic [5:0]  q100_reg, q100_next;
    logic [9:0]  q4_reg, q4_next;
    logic [21:0] base_reg, base_next;
    logic        lzero2_reg;
    // stage 3
    logic [9:0]  leap;
    logic [21:0] sum_reg, sum_next;
    // stage 4 to 6
    logic [21:0] diff;
    logic        rng4_reg, rng4_next;
    logic [15:0] dn4_reg, dn4_next;
    logic        rng5_reg;
    logic [15:0] dn5_reg;
    logic        rng6_reg;
    logic [15:0] dn6_reg;
    logic        early;

    always_comb
    begin
        early       = (in_month <= 4'd2);
        prod_next   = 21'(in_year) * 21'd365;
        part_next   = 9'(in_day) + month_prefix(in_month);
        lzero1_next = early && (in_year == 12'd0);
        ly_next     = early ? in_year - 12'd1 : in_year;

        q100_prod   = 25'(ly_reg) * 25'(RECIP_100);
        q100_next   = q100_prod[24:19];
        q4_next     = ly_reg[11:2];
        base_next   = 22'(prod_reg) + 22'(part_reg);

        // y/4 - y/100 + y/400, the last taken as (y/100)/4
        leap        = lzero2_reg ? 10'd0 : q4_reg - 10'(q100_reg) + 10'(q100_reg[5:2]);
        sum_next    = base_reg + 22'(leap);

        diff        = sum_reg - EPOCH_OFFSET;
        rng4_next   = (sum_reg >= EPOCH_OFFSET) && (sum_reg <= EPOCH_LAST);
        dn4_next    = rng4_next ? diff[15:0] : 16'd0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            prod_reg   <= prod_next;
            part_reg   <= part_next;
            ly_reg     <= ly_next;
            lzero1_reg <= lzero1_next;
        end
        if (ctrl.load[1])
        begin
            q100_reg   <= q100_next;
            q4_reg     <= q4_next;
            base_reg   <= base_next;
            lzero2_reg <= lzero1_reg;
        end
        if (ctrl.load[2])
        begin
            sum_reg <= sum_next;
        end
        if (ctrl.load[3])
        begin
            rng4_reg <= rng4_next;
            dn4_reg  <= dn4_next;
        end
        if (ctrl.load[4])
        begin
            rng5_reg <= rng4_reg;
            dn5_reg  <= dn4_reg;
        end
        if (ctrl.load[5])
        begin
            rng6_reg <= rng5_reg;
            dn6_reg  <= dn5_reg;
        end
    end

    assign day_number = dn6_reg;
    assign in_range   = rng6_reg;

endmodule

FILE: design/ddnc_to_date.sv
// day number to date datapath (era / day-of-era), six register stages
// depends on ddnc_pkg
module ddnc_to_date
    import ddnc_pkg::*;
(
    input  logic        clk,
    input  pipe_ctrl_t  ctrl,
    input  logic [15:0] in_day_number,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [11:0] year
);

    logic [19:0] z;
    logic        hi_next;
    logic [17:0] doe_next;
    logic [17:0] doe1_reg, doe2_reg, doe3_reg;
    logic        hi1_reg, hi2_reg, hi3_reg, hi4_reg, hi5_reg;
    // stage 2
    logic [31:0] q1460_prod;
    logic [6:0]  q1460_reg, q1460_next;
    logic [2:0]  cent_reg, cent_next;
    logic        last_reg, last_next;
    // stage 3
    logic [17:0] t;
    logic [33:0] yoe_prod;
    logic [8:0]  yoe_next;
    logic [8:0]  yoe3_reg, yoe4_reg, yoe5_reg;
    // stage 4
    logic [1:0]  yq100;
    logic [17:0] ydays;
    logic [17:0] doy_wide;
    logic [8:0]  doy_next;
    logic [8:0]  doy4_reg, doy5_reg;
    // stage 5
    logic [10:0] mx;
    logic [23:0] mp_prod;
    logic [3:0]  mp_next, mp_reg;
    // stage 6
    logic [8:0]  d_wide;
    logic [3:0]  m_next;
    logic [11:0] y_next;
    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [11:0] year_reg;

    always_comb
    begin
        z        = 20'(in_day_number) + MARCH_OFFSET;
        hi_next  = (z >= ERA5_START);
        doe_next = hi_next ? 18'(z - ERA5_START) : 18'(z - ERA4_START);

        q1460_prod = 32'(doe1_reg[17:2]) * 32'(RECIP_365);
        q1460_next = q1460_prod[30:24];
        if (doe1_reg == DOE_LAST)
            cent_next = 3'd4;
        else if (doe1_reg >= CENTURY_3)
            cent_next = 3'd3;
        else if (doe1_reg >= CENTURY_2)
            cent_next = 3'd2;
        else if (doe1_reg >= CENTURY_1)
            cent_next = 3'd1;
        else
            cent_next = 3'd0;
        last_next = (doe1_reg == DOE_LAST);

        t        = doe2_reg - 18'(q1460_reg) + 18'(cent_reg) - 18'(last_reg);
        yoe_prod = 34'(t) * 34'(RECIP_365);
        yoe_next = yoe_prod[32:24];

        // yoe stays below 400, so yoe/100 is a short compare chain
        if (yoe3_reg >= 9'd300)
            yq100 = 2'd3;
        else if (yoe3_reg >= 9'd200)
            yq100 = 2'd2;
        else if (yoe3_reg >= 9'd100)
            yq100 = 2'd1;
        else
            yq100 = 2'd0;
        ydays    = 18'(yoe3_reg) * 18'd365 + 18'(yoe3_reg[8:2]) - 18'(yq100);
        doy_wide = doe3_reg - ydays;
        doy_next = doy_wide[8:0];

        mx      = 11'(doy4_reg) * 11'd5 + 11'd2;
        mp_prod = 24'(mx) * 24'(RECIP_153);
        mp_next = mp_prod[23:20];

        d_wide = doy5_reg - month_start(mp_reg) + 9'd1;
        m_next = (mp_reg < 4'd10) ? mp_reg + 4'd3 : mp_reg - 4'd9;
        y_next = 12'(yoe5_reg) + (hi5_reg ? ERA5_YEAR : ERA4_YEAR)
                 + 12'(m_next <= 4'd2);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            doe1_reg <= doe_next;
            hi1_reg  <= hi_next;
        end
        if (ctrl.load[1])
        begin
            doe2_reg  <= doe1_reg;
            hi2_reg   <= hi1_reg;
            q1460_reg <= q1460_next;
            cent_reg  <= cent_next;
            last_reg  <= last_next;
        end
        if (ctrl.load[2])
        begin
            doe3_reg <= doe2_reg;
            hi3_reg  <= hi2_reg;
            yoe3_reg <= yoe_next;
        end
        if (ctrl.load[3])
        begin
            doy4_reg <= doy_next;
            yoe4_reg <= yoe3_reg;
            hi4_reg  <= hi3_reg;
        end
        if (ctrl.load[4])
        begin
            mp_reg   <= mp_next;
            doy5_reg <= doy4_reg;
            yoe5_reg <= yoe4_reg;
            hi5_reg  <= hi4_reg;
        end
        if (ctrl.load[5])
        begin
            day_reg   <= d_wide[4:0];
            month_reg <= m_next;
            year_reg  <= y_next;
        end
    end

    assign day   = day_reg;
    assign month = month_reg;
    assign year  = year_reg;

endmodule

FILE: design/date_day_number_converter.sv
// top level of the two-way calendar converter (epoch 1 january 1900)
// depends on ddnc_pkg, ddnc_in_if, ddnc_out_if, ddnc_ctrl, ddnc_to_number, ddnc_to_date
//
//   channel  role    carries
//   din      sink    op, in_day, in_month, in_year, in_day_number
//   dout     source  out_day_number, out_day, out_month, out_year, out_of_range
//
// one transfer in per cycle while din is ready; both directions are
// computed side by side in a six-stage pipeline and op picks the fields.
// reset clears only the stage valid bits.
// a stall on dout fills empty stages first; din drops ready only when all six
// stages hold an item.
module date_day_number_converter
    import ddnc_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    ddnc_in_if.sink     din,
    ddnc_out_if.source  dout
);

    pipe_ctrl_t  ctrl;
    logic        out_op;
    logic [15:0] dn;
    logic        in_range;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;

    ddnc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (din.valid),
        .in_op     (din.op),
        .in_ready  (din.ready),
        .out_valid (dout.valid),
        .out_op    (out_op),
        .out_ready (dout.ready),
        .ctrl      (ctrl)
    );

    ddnc_to_number u_to_number (
        .clk        (clk),
        .ctrl       (ctrl),
        .in_day     (din.in_day),
        .in_month   (din.in_month),
        .in_year    (din.in_year),
        .day_number (dn),
        .in_range   (in_range)
    );

    ddnc_to_date u_to_date (
        .clk           (clk),
        .ctrl          (ctrl),
        .in_day_number (din.in_day_number),
        .day           (day),
        .month         (month),
        .year          (year)
    );

    // fields of the other direction read as zero
    assign dout.out_day_number = out_op ? 16'd0 : dn;
    assign dout.out_of_range   = !out_op && !in_range;
    assign dout.out_day        = out_op ? day : 5'd0;
    assign dout.out_month      = out_op ? month : 4'd0;
    assign dout.out_year       = out_op ? year : 12'd0;

endmodule
